[src/lnf_pkg.sv]
// ----------------------------------------------------------------------------
// lnf_pkg
// Shared widths, register indexes and rounding helpers for the low-pass
// notch IIR filter.
// ----------------------------------------------------------------------------
package lnf_pkg;

	// Sample format: signed Q(SAMPLE_WIDTH-FRAC_BITS).FRAC_BITS
	localparam int SAMPLE_WIDTH = 32;
	localparam int FRAC_BITS    = 16;

	// Coefficient widths: scale Q0.F unsigned, zero Q2.F unsigned, pole Q1.F signed
	localparam int SCALE_W = FRAC_BITS;
	localparam int ZERO_W  = FRAC_BITS + 2;
	localparam int POLE_W  = FRAC_BITS + 1;

	// Configuration port
	localparam int CFG_W     = ZERO_W;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_SCALE = 2'd0,
		REG_ZERO_COEF   = 2'd1,
		REG_POLE_COEF   = 2'd2
	} lnf_reg_t;

	localparam logic [SCALE_W-1:0]       INPUT_SCALE_RST = SCALE_W'(4234);
	localparam logic [ZERO_W-1:0]        ZERO_COEF_RST   = ZERO_W'(68281);
	localparam logic signed [POLE_W-1:0] POLE_COEF_RST   = POLE_W'(48247);

	// Rounding constant: one half in the product's fraction
	localparam int HALF = 1 << (FRAC_BITS - 1);

	// Zero and pole coefficients handed to the filter section
	typedef struct packed {
		logic [ZERO_W-1:0]        zero;
		logic signed [POLE_W-1:0] pole;
	} lnf_coef_t;

endpackage

[src/lnf_section.sv]
// ----------------------------------------------------------------------------
// lnf_section
// Recursive part of the filter: delay line, notch term, pole feedback,
// saturation and the result register.
// ----------------------------------------------------------------------------
module lnf_section import lnf_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic signed [SAMPLE_WIDTH-1:0] x3,
	input  logic signed [SAMPLE_WIDTH-1:0] raw,
	input  lnf_coef_t                      coef,
	output logic signed [SAMPLE_WIDTH-1:0] y_q
);

	localparam int SUM_W  = SAMPLE_WIDTH + 1;
	localparam int ZP_W   = SUM_W + ZERO_W + 1;
	localparam int ZT_W   = ZP_W - FRAC_BITS;
	localparam int PP_W   = SAMPLE_WIDTH + POLE_W;
	localparam int PT_W   = PP_W - FRAC_BITS;
	localparam int ACC_W  = SAMPLE_WIDTH + 5;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		ACC_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

	logic signed [SAMPLE_WIDTH-1:0] hist_q [3];
	logic signed [SAMPLE_WIDTH-1:0] last_q;
	logic                           primed_q;

	logic signed [SAMPLE_WIDTH-1:0] x0, x1, x2, yp;
	logic signed [SUM_W-1:0]        mid_sum;
	logic signed [ZP_W-1:0]         zero_prod;
	logic signed [ZT_W-1:0]         zero_term;
	logic signed [PP_W-1:0]         pole_prod;
	logic signed [PT_W-1:0]         pole_term;
	logic signed [ACC_W-1:0]        acc;
	logic signed [SAMPLE_WIDTH-1:0] y;

	// Before the first sample the delay line reads as the current sample and the previous output as the raw one
	always_comb begin
		x0 = primed_q ? hist_q[0] : x3;
		x1 = primed_q ? hist_q[1] : x3;
		x2 = primed_q ? hist_q[2] : x3;
		yp = primed_q ? last_q    : raw;
	end

	// Notch term on the two middle taps, rounded half up
	always_comb begin
		mid_sum   = SUM_W'(x1) + SUM_W'(x2);
		zero_prod = ZP_W'(mid_sum) * $signed(ZP_W'({1'b0, coef.zero})) + ZP_W'(HALF);
		zero_term = zero_prod[FRAC_BITS +: ZT_W];
	end

	// Pole feedback on the previous output, rounded half up
	always_comb begin
		pole_prod = PP_W'(yp) * PP_W'(coef.pole) + PP_W'(HALF);
		pole_term = pole_prod[FRAC_BITS +: PT_W];
	end

	// Sum and clamp to the sample range
	always_comb begin
		acc = ACC_W'(x0) + ACC_W'(x3) + ACC_W'(zero_term) + ACC_W'(pole_term);
		if (acc > SAT_MAX) begin
			y = SAT_MAX[SAMPLE_WIDTH-1:0];
		end else if (acc < SAT_MIN) begin
			y = SAT_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y = acc[SAMPLE_WIDTH-1:0];
		end
	end

	// Mark the section primed after the first word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (load) begin
			primed_q <= 1'b1;
		end
	end

	// Shift the delay line and keep the result
	always_ff @(posedge clk) begin
		if (load) begin
			hist_q[0] <= x1;
			hist_q[1] <= x2;
			hist_q[2] <= x3;
			last_q    <= y;
			y_q       <= y;
		end
	end

endmodule

[src/lowpass_notch_iir_filter.sv]
// ----------------------------------------------------------------------------
// lowpass_notch_iir_filter
// First-order low-pass IIR filter with a notch on signed Q16.16 samples.
// ----------------------------------------------------------------------------
// The filter takes one sample word per clock while filtered_stall is low and
// returns one filtered word per sample: the first register holds the sample
// scaled by input_scale, the second holds the saturated result. The rate is
// set by the pole feedback loop, one multiply-add and clamp per cycle.
// The first sample after reset fills the delay line with its own scaled value
// and uses the raw sample as the previous output.
// Write the coefficient registers only while no sample is in flight.
module lowpass_notch_iir_filter import lnf_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           wr_en,
	input  logic [CFG_IDX_W-1:0]           wr_index,
	input  logic [CFG_W-1:0]               wr_data,
	// Sample input
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	// Filtered output
	output logic                           filtered_valid,
	input  logic                           filtered_stall,
	output logic signed [SAMPLE_WIDTH-1:0] filtered
);

	localparam int SP_W = SAMPLE_WIDTH + SCALE_W + 1;

	logic [SCALE_W-1:0] input_scale_q;
	lnf_coef_t          coef_q;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] x3_s1;
	logic signed [SAMPLE_WIDTH-1:0] raw_s1;
	logic                           valid_s2;

	logic                           take_s2;
	logic                           take_s1;
	logic signed [SP_W-1:0]         scale_prod;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_scale_q <= INPUT_SCALE_RST;
			coef_q.zero   <= ZERO_COEF_RST;
			coef_q.pole   <= POLE_COEF_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_INPUT_SCALE: input_scale_q <= wr_data[SCALE_W-1:0];
				REG_ZERO_COEF:   coef_q.zero   <= wr_data[ZERO_W-1:0];
				REG_POLE_COEF:   coef_q.pole   <= $signed(wr_data[POLE_W-1:0]);
				default:         ;
			endcase
		end
	end

	// Handshake: each stage advances when the one after it has room
	assign take_s2      = valid_s1 && (!valid_s2 || !filtered_stall);
	assign take_s1      = !valid_s1 || take_s2;
	assign sample_stall = !take_s1;

	// Scale the incoming sample, rounded half up
	assign scale_prod = SP_W'(sample) * $signed(SP_W'({1'b0, input_scale_q}))
		+ SP_W'(HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= sample_valid;
			end
			if (take_s2) begin
				valid_s2 <= 1'b1;
			end else if (!filtered_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Hold the scaled word for the recursive section
	always_ff @(posedge clk) begin
		if (take_s1 && sample_valid) begin
			x3_s1  <= scale_prod[FRAC_BITS +: SAMPLE_WIDTH];
			raw_s1 <= sample;
		end
	end

	lnf_section u_section (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take_s2),
		.x3     (x3_s1),
		.raw    (raw_s1),
		.coef   (coef_q),
		.y_q    (filtered)
	);

	assign filtered_valid = valid_s2;

endmodule
